// ===== sv/mrlf_pkg.sv =====
// ----------------------------------------------------------------------------
// mrlf_pkg
// Shared types and codes for the learning route table with ttl preference.
// ----------------------------------------------------------------------------
`default_nettype none

package mrlf_pkg;

    localparam int LINK_W = 2;
    localparam int TTL_W  = 8;
    localparam int CFG_W  = 8;
    localparam int FID_W  = 8;
    localparam int ACT_W  = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOCAL    = 2'd0,
        ACT_FORWARD  = 2'd1,
        ACT_EXPIRED  = 2'd2,
        ACT_NO_ROUTE = 2'd3
    } t_action;

    // search token handed from cell to cell
    typedef struct packed {
        logic              active;
        logic              link_ok;
        logic              src_done;
        logic              learned;
        logic              dst_hit;
        logic [LINK_W-1:0] dst_link;
    } t_tok;

endpackage

`default_nettype wire

// ===== sv/mrlf_cell.sv =====
// ----------------------------------------------------------------------------
// mrlf_cell
// One route table entry; learns from and looks up the passing search token.
// ----------------------------------------------------------------------------
`default_nettype none

module mrlf_cell
    import mrlf_pkg::*;
#(
    parameter int ID_BITS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_tok               i_tok,
    input  wire logic [ID_BITS-1:0] i_src,
    input  wire logic [ID_BITS-1:0] i_dst,
    input  wire logic [TTL_W-1:0]   i_ttl,
    input  wire logic [LINK_W-1:0]  i_link,
    output t_tok                    o_tok
);

    logic               r_valid;
    logic [ID_BITS-1:0] r_dev;
    logic [LINK_W-1:0]  r_link;
    logic [TTL_W-1:0]   r_hops;
    t_tok               r_tok;
    t_tok               n_tok;

    logic               w_seek;
    logic               w_match_src;
    logic               w_ins;
    logic               w_upd;
    logic               w_post_valid;
    logic [ID_BITS-1:0] w_post_dev;
    logic [LINK_W-1:0]  w_post_link;
    logic               w_dst_match;

    always_comb begin
        w_seek       = i_tok.active && i_tok.link_ok && !i_tok.src_done;
        w_match_src  = w_seek && r_valid && (r_dev == i_src);
        // entries fill from the lowest index, so the first free one ends the valid run
        w_ins        = w_seek && !r_valid;
        w_upd        = w_match_src && (r_hops <= i_ttl);
        w_post_valid = r_valid || w_ins;
        w_post_dev   = w_ins ? i_src : r_dev;
        w_post_link  = (w_ins || w_upd) ? i_link : r_link;
        // lookup sees the entry as just learned from this packet
        w_dst_match  = i_tok.active && !i_tok.dst_hit && w_post_valid && (w_post_dev == i_dst);

        n_tok          = i_tok;
        n_tok.src_done = i_tok.src_done || w_match_src || w_ins;
        n_tok.learned  = i_tok.learned || w_ins || w_upd;
        if (w_dst_match) begin
            n_tok.dst_hit  = 1'b1;
            n_tok.dst_link = w_post_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_tok <= n_tok;
            if (w_ins) begin
                r_valid <= 1'b1;
            end
        end
        if (w_ins) begin
            r_dev <= i_src;
        end
        if (w_ins || w_upd) begin
            r_link <= i_link;
            r_hops <= i_ttl;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// ===== sv/mesh_route_learn_forward_core.sv =====
// ----------------------------------------------------------------------------
// mesh_route_learn_forward_core
// Learning route table with ttl preference and local/forward/drop decision.
// ----------------------------------------------------------------------------
// A header is taken when start is high and busy is low. A search token then
// walks the row of ENTRIES table cells, one cell per cycle: each cell learns
// the source route when the token passes and checks the destination against
// its entry. The result is registered after the token leaves the last cell
// and is marked by o_result_valid for one cycle; it cannot be held off.
// busy drops in that same cycle, so a new header is taken only after the
// last result is out. own_id is written through the cfg channel, which is
// always ready; write it only while busy is low.
`default_nettype none

module mesh_route_learn_forward_core
    import mrlf_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int LINKS   = 4,
    parameter int ID_BITS = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [LINK_W-1:0] i_arrival_link,
    input  wire logic [FID_W-1:0]  i_source_id,
    input  wire logic [FID_W-1:0]  i_destination_id,
    input  wire logic [TTL_W-1:0]  i_ttl,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    output logic                   o_result_valid,
    output logic [ACT_W-1:0]       o_action,
    output logic [LINK_W-1:0]      o_out_link,
    output logic [TTL_W-1:0]       o_out_ttl,
    output logic                   o_route_learned,
    output logic                   o_table_full
);

    logic               r_busy;
    logic [CFG_W-1:0]   r_own_id;
    t_tok               r_tok0;
    logic [ID_BITS-1:0] r_src;
    logic [ID_BITS-1:0] r_dst;
    logic [TTL_W-1:0]   r_ttl;
    logic [LINK_W-1:0]  r_link;
    logic               r_local;

    logic               r_result_valid;
    t_action            r_action;
    logic [LINK_W-1:0]  r_out_link;
    logic [TTL_W-1:0]   r_out_ttl;
    logic               r_learned;
    logic               r_full;

    t_tok               w_tok [ENTRIES+1];
    logic [ENTRIES-1:0] w_act;
    t_tok               w_end;
    logic               w_accept;

    t_tok               n_tok0;
    t_action            n_action;
    logic [LINK_W-1:0]  n_out_link;
    logic [TTL_W-1:0]   n_out_ttl;

    assign w_accept = start && !r_busy;
    assign w_tok[0] = r_tok0;
    assign w_end    = w_tok[ENTRIES];

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            mrlf_cell #(
                .ID_BITS (ID_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_tok   (w_tok[g]),
                .i_src   (r_src),
                .i_dst   (r_dst),
                .i_ttl   (r_ttl),
                .i_link  (r_link),
                .o_tok   (w_tok[g+1])
            );
            assign w_act[g] = w_tok[g+1].active;
        end
    endgenerate

    always_comb begin
        n_tok0 = '0;
        if (w_accept) begin
            n_tok0.active  = 1'b1;
            n_tok0.link_ok = (32'(i_arrival_link) < LINKS);
        end
    end

    always_comb begin
        n_out_link = '0;
        n_out_ttl  = '0;
        if (r_local) begin
            n_action = ACT_LOCAL;
        end else if (r_ttl <= TTL_W'(1)) begin
            n_action = ACT_EXPIRED;
        end else if (w_end.dst_hit) begin
            n_action   = ACT_FORWARD;
            n_out_link = w_end.dst_link;
            n_out_ttl  = r_ttl - TTL_W'(1);
        end else begin
            n_action = ACT_NO_ROUTE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_own_id       <= '0;
            r_tok0         <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= w_end.active;
            if (i_cfg_valid) begin
                r_own_id <= i_cfg_data;
            end
            r_tok0 <= n_tok0;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_end.active) begin
                r_busy <= 1'b0;
            end
        end
        if (w_accept) begin
            r_src   <= ID_BITS'(i_source_id);
            r_dst   <= ID_BITS'(i_destination_id);
            r_ttl   <= i_ttl;
            r_link  <= i_arrival_link;
            r_local <= (ID_BITS'(i_destination_id) == ID_BITS'(r_own_id));
        end
        if (w_end.active) begin
            r_action   <= n_action;
            r_out_link <= n_out_link;
            r_out_ttl  <= n_out_ttl;
            r_learned  <= w_end.learned;
            r_full     <= w_end.link_ok && !w_end.src_done;
        end
    end

    assign busy            = r_busy;
    assign o_cfg_ready     = 1'b1;
    assign o_result_valid  = r_result_valid;
    assign o_action        = r_action;
    assign o_out_link      = r_out_link;
    assign o_out_ttl       = r_out_ttl;
    assign o_route_learned = r_learned;
    assign o_table_full    = r_full;

    // at most one token travels the chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_act, r_tok0.active}))
        else $error("more than one search token in the cell chain");

    a_token_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tok0.active || (w_act != '0)) |-> r_busy)
        else $error("search token in flight while not busy");

    a_learn_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_result_valid |-> !(r_learned && r_full))
        else $error("route learned and table full on the same result");

    a_fwd_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_result_valid && (r_action != ACT_FORWARD)) |->
            ((r_out_link == '0) && (r_out_ttl == '0)))
        else $error("link or ttl set on a result that is not forwarded");

    a_result_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_result_valid |-> (!r_busy && $past(w_end.active)))
        else $error("result without a finished search");

endmodule

`default_nettype wire
